// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the keypad event encoder.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define KCEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication held in the next cycle, disabled while reset is asserted.
`define KCEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kcee_pkg.sv
// Shared constants of the keypad change event encoder.
// No dependencies; used by the top level, the column store, the checker and the testbench.
package kcee_pkg;

  // Default keypad geometry.
  localparam int unsigned COLUMNS_DEF = 8;
  localparam int unsigned ROWS_DEF    = 8;

  // Fixed field widths of the words on the ports.
  localparam int unsigned COLUMN_W   = 3;
  localparam int unsigned ROW_BITS_W = 8;
  localparam int unsigned CODE_W     = 8;

  // Code distance between neighboring keys.
  localparam logic [CODE_W-1:0] KEY_STEP = 8'd2;

endpackage

// File: rtl/kcee_col_store.sv
// Per-column store of the last seen row bitmap, with the change mask of a scan.
// Depends on kcee_pkg for the defaults of its parameters.
module kcee_col_store #(
  parameter int unsigned COLUMNS = kcee_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = kcee_pkg::ROWS_DEF,
  localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [COL_W-1:0] col_i,
  input  logic [ROWS-1:0]  rows_i,
  output logic [ROWS-1:0]  changed_o
);

  logic [ROWS-1:0] prev_q [COLUMNS];

  // Rows whose state differs from the stored bitmap of this column.
  assign changed_o = rows_i ^ prev_q[col_i];

  // Store the new bitmap; reset means no key pressed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) begin
        prev_q[c] <= '0;
      end
    end else if (we_i) begin
      prev_q[col_i] <= rows_i;
    end
  end

endmodule

// File: rtl/keypad_change_event_encoder.sv
// Top level of the keypad change event encoder: sequencer, code adder, output word.
// Depends on kcee_pkg and kcee_col_store.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o | column_i, row_bits_i
//   out     | output    | out_valid_o/out_stall_i | event_code_o, pressed_o, is_last_o
//   cfg     | input     | cfg_we_i                | cfg_wdata_i (event base)
//
// A scan is taken while the sequencer is idle; the row walk with its code adder then steps
// from row 0 up to the highest changed row, one row per step.
// The walk holds on a changed row while the output word is stalled.
// A scan of a column at or above COLUMNS, or without change, is taken but starts no walk.
// Reset clears the stored column bitmaps and the event base at once.
module keypad_change_event_encoder #(
  parameter int unsigned COLUMNS = kcee_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = kcee_pkg::ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kcee_pkg::CODE_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kcee_pkg::COLUMN_W-1:0]   column_i,
  input  logic [kcee_pkg::ROW_BITS_W-1:0] row_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kcee_pkg::CODE_W-1:0]     event_code_o,
  output logic                            pressed_o,
  output logic                            is_last_o
);

  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [kcee_pkg::CODE_W-1:0] COL_STEP = kcee_pkg::CODE_W'((2 * ROWS) % 256);
  localparam logic [kcee_pkg::COLUMN_W:0] COL_LIMIT = (kcee_pkg::COLUMN_W + 1)'(COLUMNS);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                      state_q;
  logic [kcee_pkg::CODE_W-1:0] base_q;
  logic [kcee_pkg::CODE_W-1:0] code_q;
  logic [ROW_W-1:0]            row_q;
  logic [ROWS-1:0]             pend_q;
  logic [ROWS-1:0]             rows_q;
  logic                        out_valid_q;
  logic [kcee_pkg::CODE_W-1:0] out_code_q;
  logic                        out_pressed_q;
  logic                        out_last_q;

  logic                        in_acc;
  logic                        col_ok;
  logic [ROWS-1:0]             rows_in;
  logic [ROWS-1:0]             changed;
  logic                        out_free;
  logic                        emit;
  logic [ROWS-1:0]             pend_rest;
  logic [kcee_pkg::CODE_W-1:0] code_step;
  logic [kcee_pkg::CODE_W-1:0] code_emit;
  logic [kcee_pkg::CODE_W-1:0] code_start;
  logic                        down;

  // Input side: a scan is taken only while the sequencer is idle.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign col_ok     = {1'b0, column_i} < COL_LIMIT;
  assign rows_in    = row_bits_i[ROWS-1:0];

  kcee_col_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_col_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (in_acc && col_ok),
    .col_i     (column_i[COL_W-1:0]),
    .rows_i    (rows_in),
    .changed_o (changed)
  );

  // Code of the first key in the column, and the row walk adder.
  assign code_start = base_q + kcee_pkg::CODE_W'({5'b0, column_i} * COL_STEP);
  assign code_step  = code_q + kcee_pkg::KEY_STEP;
  assign down       = rows_q[row_q];
  assign code_emit  = code_q + {7'b0, !down};

  // Changed rows still to report once the current one is out.
  assign pend_rest = pend_q & ~(ROWS'(1) << row_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == ST_SCAN) && pend_q[row_q] && out_free;

  // Sequencer, event base and output word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      base_q        <= '0;
      code_q        <= '0;
      row_q         <= '0;
      pend_q        <= '0;
      rows_q        <= '0;
      out_valid_q   <= 1'b0;
      out_code_q    <= '0;
      out_pressed_q <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && col_ok && (changed != '0)) begin
            state_q <= ST_SCAN;
            pend_q  <= changed;
            rows_q  <= rows_in;
            row_q   <= '0;
            code_q  <= code_start;
          end
        end
        ST_SCAN: begin
          if (pend_q[row_q]) begin
            if (out_free) begin
              out_code_q    <= code_emit;
              out_pressed_q <= down;
              out_last_q    <= (pend_rest == '0);
              pend_q        <= pend_rest;
              if (pend_rest == '0) begin
                state_q <= ST_IDLE;
              end else begin
                row_q  <= row_q + ROW_W'(1);
                code_q <= code_step;
              end
            end
          end else begin
            row_q  <= row_q + ROW_W'(1);
            code_q <= code_step;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = out_code_q;
  assign pressed_o    = out_pressed_q;
  assign is_last_o    = out_last_q;

endmodule

// File: rtl/kcee_checker.sv
// Port-level checker of the keypad change event encoder, bound to the top level.
// Depends on kcee_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcee_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [kcee_pkg::CODE_W-1:0]     cfg_wdata_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [kcee_pkg::CODE_W-1:0]     event_code_o,
  input logic                            pressed_o,
  input logic                            is_last_o
);

  logic [kcee_pkg::CODE_W-1:0] base_q;

  // Shadow copy of the event base as written on the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // A stalled output word stays put.
  `KCEE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(event_code_o) && $stable(pressed_o) && $stable(is_last_o), "stalled output word changed")

  // While a word that is not the last of its scan waits, no new scan is taken.
  `KCEE_ASSERT(a_busy_mid_run, (out_valid_o && !is_last_o) |-> in_stall_o, "scan taken in the middle of an event run")

  // Press codes share the parity of the base; release codes are one above.
  `KCEE_ASSERT(a_code_parity, out_valid_o |-> (event_code_o[0] == (base_q[0] ^ !pressed_o)), "event code parity does not match press or release")

endmodule

bind keypad_change_event_encoder kcee_checker u_kcee_checker (.*);

// File: dv/tb_keypad_change_event_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench of keypad_change_event_encoder: column scans in, key events out.
// Depends on kcee_pkg and the encoder RTL; stands alone otherwise.
module tb_keypad_change_event_encoder;

  localparam int unsigned COLUMN_W   = kcee_pkg::COLUMN_W;
  localparam int unsigned ROW_BITS_W = kcee_pkg::ROW_BITS_W;
  localparam int unsigned CODE_W     = kcee_pkg::CODE_W;
  localparam int unsigned COLUMNS = kcee_pkg::COLUMNS_DEF;
  localparam int unsigned ROWS    = kcee_pkg::ROWS_DEF;
  localparam logic [ROW_BITS_W-1:0] ROW_MASK = ROW_BITS_W'((1 << ROWS) - 1);
  // Idle time between phases, sized to a full row walk with some margin.
  localparam int DRAIN_CYCLES = ROWS + 4;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_SCANS = 43;

  // One column scan as the sender presents it.
  typedef struct packed {
    logic [COLUMN_W-1:0]   column;
    logic [ROW_BITS_W-1:0] rows;
  } scan_word_t;

  // One key event as the encoder should emit it.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              pressed;
    logic              is_last;
  } key_event_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CODE_W-1:0]     cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [COLUMN_W-1:0]   column_i    = '0;
  logic [ROW_BITS_W-1:0] row_bits_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CODE_W-1:0]     event_code_o;
  logic                  pressed_o;
  logic                  is_last_o;

  // Stimulus side.
  scan_word_t            pending_scans[$];
  scan_word_t            next_scan;
  logic [ROW_BITS_W-1:0] stim_rows[COLUMNS];
  int                    scans_queued = 0;
  int                    scans_taken  = 0;
  int                    in_gap       = 0;
  int                    stall_left   = 0;
  logic                  in_fire      = 1'b0;
  logic                  calm         = 1'b0;

  // Prediction side: its own copy of the column bitmaps and the event base.
  logic [ROW_BITS_W-1:0] seen_rows[COLUMNS];
  logic [CODE_W-1:0]     code_base = '0;
  key_event_t            expected_events[$];
  key_event_t            want;
  int                    mismatch_count = 0;

  keypad_change_event_encoder #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .column_i    (column_i),
    .row_bits_i  (row_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_code_o(event_code_o),
    .pressed_o   (pressed_o),
    .is_last_o   (is_last_o)
  );

  always #2 clk_i = ~clk_i;

  // Work out the key events one scan causes and update the stored bitmap.
  function automatic void predict_key_events(input logic [COLUMN_W-1:0] col,
                                             input logic [ROW_BITS_W-1:0] rows_in);
    logic [ROW_BITS_W-1:0] rows;
    logic [ROW_BITS_W-1:0] changed;
    key_event_t            ev;
    int                    first_idx;
    int                    key_index;
    rows = rows_in & ROW_MASK;
    if (col >= COLUMNS) return;
    changed = (rows ^ seen_rows[col]) & ROW_MASK;
    first_idx = expected_events.size();
    for (int r = 0; r < ROWS; r++) begin
      if (changed[r]) begin
        key_index  = int'(col) * ROWS + r;
        ev.pressed = rows[r];
        ev.code    = code_base + CODE_W'(key_index * 2) + (rows[r] ? 8'd0 : 8'd1);
        ev.is_last = 1'b0;
        expected_events.push_back(ev);
      end
    end
    if (expected_events.size() > first_idx)
      expected_events[expected_events.size() - 1].is_last = 1'b1;
    seen_rows[col] = rows;
  endfunction

  // Sender: presents queued scans at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_scans.size() > 0) begin
        next_scan = pending_scans.pop_front();
        column_i   <= next_scan.column;
        row_bits_i <= next_scan.rows;
        in_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls the event word in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: tracks config writes and accepted scans, checks each event word.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) code_base = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        predict_key_events(column_i, row_bits_i);
        scans_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $error("event word with nothing expected: event_code %0h pressed %0b is_last %0b",
                 event_code_o, pressed_o, is_last_o);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          if (event_code_o !== want.code) begin
            $error("event_code: expected %0h, actual %0h", want.code, event_code_o);
            mismatch_count++;
          end
          if (pressed_o !== want.pressed) begin
            $error("pressed: expected %0b, actual %0b", want.pressed, pressed_o);
            mismatch_count++;
          end
          if (is_last_o !== want.is_last) begin
            $error("is_last: expected %0b, actual %0b", want.is_last, is_last_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic queue_scan(input logic [COLUMN_W-1:0] col, input logic [ROW_BITS_W-1:0] rows);
    scan_word_t s;
    s.column = col;
    s.rows   = rows;
    pending_scans.push_back(s);
    scans_queued++;
    if (col < COLUMNS) stim_rows[col] = rows & ROW_MASK;
  endtask

  // Waits until every scan is taken and every event has come out, then idles
  // for DRAIN_CYCLES before the next phase.
  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (scans_taken != scans_queued || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_event_base(input logic [CODE_W-1:0] value);
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Main sequence: reset, directed scans at two bases, then random phases.
  initial begin
    logic [CODE_W-1:0]     phase_base[RANDOM_PHASES];
    logic [COLUMN_W-1:0]   col;
    logic [ROW_BITS_W-1:0] rows;
    int                    kind;
    for (int c = 0; c < COLUMNS; c++) begin
      seen_rows[c] = '0;
      stim_rows[c] = '0;
    end
    phase_base[0] = 8'h80;
    phase_base[1] = CODE_W'($urandom);
    phase_base[2] = 8'h00;
    phase_base[3] = 8'hFF;
    phase_base[4] = CODE_W'($urandom);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset base: all keys of a column at once, no change, mixed press and release.
    queue_scan(3'd0, 8'hFF);
    queue_scan(3'd0, 8'hFF);
    queue_scan(3'd0, 8'h00);
    queue_scan(3'd7, 8'h80);
    queue_scan(3'd7, 8'h01);
    queue_scan(3'd3, 8'hA5);
    queue_scan(3'd3, 8'h5A);
    queue_scan(3'd5, 8'h00);
    queue_scan(3'd7, 8'hFF);
    queue_scan(3'd1, 8'h01);
    wait_until_drained();

    // Highest base: codes wrap around past 255.
    write_event_base(8'hFF);
    queue_scan(3'd7, 8'h00);
    queue_scan(3'd0, 8'h01);
    queue_scan(3'd0, 8'h00);
    queue_scan(3'd6, 8'hC3);
    queue_scan(3'd2, 8'h80);
    queue_scan(3'd4, 8'hFF);
    wait_until_drained();

    // Random phases: mostly one or two keys toggling, some whole-column changes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      write_event_base(phase_base[p]);
      for (int i = 0; i < PHASE_SCANS; i++) begin
        col  = COLUMN_W'($urandom_range(0, COLUMNS - 1));
        kind = $urandom_range(0, 9);
        rows = stim_rows[col];
        if (kind <= 5) begin
          rows[$urandom_range(0, ROWS - 1)] ^= 1'b1;
          if ($urandom_range(0, 2) == 0) rows[$urandom_range(0, ROWS - 1)] ^= 1'b1;
        end else if (kind <= 7) begin
          rows = ROW_BITS_W'($urandom);
        end else if (kind == 9) begin
          rows = (rows == ROW_MASK) ? '0 : ROW_MASK;
        end
        queue_scan(col, rows);
      end
      wait_until_drained();
    end

    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/kcee_pkg.sv
rtl/kcee_col_store.sv
rtl/keypad_change_event_encoder.sv
rtl/kcee_checker.sv
dv/tb_keypad_change_event_encoder.sv
